// ===== sv/rss_pkg.sv =====
// rss_pkg: shared types and constants for the range scan object segmenter
// payload structs for the sample and result channels, register indexes, limits
// no dependencies
package rss_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);

  localparam int IR_W    = 12;
  localparam int PING_W  = 10;
  localparam int ANGLE_W = 9;
  localparam int NUM_W   = 4;
  localparam int RUN_W   = 8;
  localparam int TOL_W   = 8;
  localparam int ANCH_W  = 6;   // anchors never exceed the anchor limit

  localparam logic [IR_W-1:0]   ANCHOR_LIMIT = IR_W'(40);
  localparam logic [ANCH_W-1:0] BAND_FAR     = ANCH_W'(35);
  localparam logic [ANCH_W-1:0] BAND_MID     = ANCH_W'(30);
  localparam logic [ANCH_W-1:0] BAND_NEAR    = ANCH_W'(10);

  localparam logic [TOL_W-1:0] TOL_FAR_RST   = TOL_W'(20);
  localparam logic [TOL_W-1:0] TOL_MID_RST   = TOL_W'(14);
  localparam logic [TOL_W-1:0] TOL_NEAR_RST  = TOL_W'(9);
  localparam logic [TOL_W-1:0] TOL_CLOSE_RST = TOL_W'(4);
  localparam logic [NUM_W-1:0] MAX_OBJ_RST   = NUM_W'(4);
  localparam logic [NUM_W-1:0] MAX_OBJ_CAP   = NUM_W'(8);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL_FAR     = 3'd0,
    REG_TOL_MID     = 3'd1,
    REG_TOL_NEAR    = 3'd2,
    REG_TOL_CLOSE   = 3'd3,
    REG_MAX_OBJECTS = 3'd4
  } reg_index_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [IR_W-1:0]   ir_distance;
    logic [PING_W-1:0] ping_distance;
    logic              last_sample;
  } sample_t;

  typedef struct packed {
    logic               is_summary;
    logic [NUM_W-1:0]   object_number;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] width_degrees;
    logic [PING_W-1:0]  object_range;
    logic [NUM_W-1:0]   object_count;
    logic               last_result;
  } result_t;

  // results caused by one sample, packed from entry 0 upwards
  typedef struct packed {
    logic [1:0]        count;
    result_t [1:0]     item;
  } push_t;

endpackage

// ===== sv/rss_core.sv =====
// rss_core: per-sample segmentation logic, sweep state and tolerance registers
// depends on rss_pkg
module rss_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          step,
  input  rss_pkg::sample_t              sample,
  output rss_pkg::push_t                push
);

  logic [rss_pkg::TOL_W-1:0] tol_far, tol_mid, tol_near, tol_close;
  logic [rss_pkg::NUM_W-1:0] max_objects;

  logic [rss_pkg::IDX_W-1:0]  sample_index, sample_index_next;
  logic                       anchor_valid, anchor_valid_next;
  logic [rss_pkg::ANCH_W-1:0] anchor_range, anchor_range_next;
  logic [rss_pkg::IDX_W-1:0]  anchor_index, anchor_index_next;
  logic [rss_pkg::RUN_W-1:0]  run_length, run_length_next;
  logic                       object_open, object_open_next;
  logic [rss_pkg::PING_W-1:0] matched_ping, matched_ping_next;
  logic [rss_pkg::NUM_W-1:0]  objects_found, objects_found_next;

  logic                       last;
  logic [rss_pkg::NUM_W-1:0]  cap;
  logic [rss_pkg::IR_W-1:0]   anchor_ext;
  logic [rss_pkg::IR_W-1:0]   diff;
  logic [rss_pkg::TOL_W-1:0]  tol;
  logic                       active, match, miss, rec_miss, rec_last, rec;
  logic [rss_pkg::NUM_W-1:0]  obj_num, obj_total;
  rss_pkg::result_t           record, summary;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_far     <= rss_pkg::TOL_FAR_RST;
      tol_mid     <= rss_pkg::TOL_MID_RST;
      tol_near    <= rss_pkg::TOL_NEAR_RST;
      tol_close   <= rss_pkg::TOL_CLOSE_RST;
      max_objects <= rss_pkg::MAX_OBJ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rss_pkg::REG_TOL_FAR:     tol_far     <= cfg_data;
        rss_pkg::REG_TOL_MID:     tol_mid     <= cfg_data;
        rss_pkg::REG_TOL_NEAR:    tol_near    <= cfg_data;
        rss_pkg::REG_TOL_CLOSE:   tol_close   <= cfg_data;
        rss_pkg::REG_MAX_OBJECTS: max_objects <= cfg_data[rss_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cap  = (max_objects > rss_pkg::MAX_OBJ_CAP) ? rss_pkg::MAX_OBJ_CAP : max_objects;
  assign last = sample.last_sample ||
                (sample_index == rss_pkg::IDX_W'(rss_pkg::MAX_SAMPLES - 1));

  // tolerance band of the current anchor
  always_comb begin
    priority if (anchor_range > rss_pkg::BAND_FAR) tol = tol_far;
    else if (anchor_range >= rss_pkg::BAND_MID)    tol = tol_mid;
    else if (anchor_range >= rss_pkg::BAND_NEAR)   tol = tol_near;
    else                                           tol = tol_close;
  end

  assign anchor_ext = rss_pkg::IR_W'(anchor_range);
  assign diff   = (sample.ir_distance > anchor_ext) ? sample.ir_distance - anchor_ext
                                                    : anchor_ext - sample.ir_distance;
  assign active = (sample_index != '0);
  assign match  = active && anchor_valid && (diff <= rss_pkg::IR_W'(tol));
  assign miss   = active && anchor_valid && !match;

  always_comb begin
    anchor_valid_next = anchor_valid;
    anchor_range_next = anchor_range;
    anchor_index_next = anchor_index;
    run_length_next   = run_length;
    object_open_next  = object_open;
    matched_ping_next = matched_ping;

    if (match) begin
      run_length_next   = run_length + 1'b1;
      matched_ping_next = sample.ping_distance;
      if (run_length_next == rss_pkg::RUN_W'(1) && objects_found < cap) begin
        object_open_next = 1'b1;
      end
    end else if (miss) begin
      anchor_valid_next = 1'b0;
      run_length_next   = '0;
      object_open_next  = 1'b0;
    end

    // the closing sample is itself tried as the next anchor
    if (active && !match && sample.ir_distance <= rss_pkg::ANCHOR_LIMIT) begin
      anchor_valid_next = 1'b1;
      anchor_range_next = sample.ir_distance[rss_pkg::ANCH_W-1:0];
      anchor_index_next = sample_index;
      run_length_next   = '0;
      object_open_next  = 1'b0;
    end
  end

  // a miss can only close the old run; a run open at the end closes on the last sample
  assign rec_miss  = miss && object_open;
  assign rec_last  = last && anchor_valid_next && object_open_next;
  assign rec       = rec_miss || rec_last;
  assign obj_num   = objects_found + 1'b1;
  assign obj_total = rec ? obj_num : objects_found;

  always_comb begin
    record               = '0;
    record.object_number = obj_num;
    record.last_result   = !last;
    if (rec_miss) begin
      record.start_angle   = rss_pkg::ANGLE_W'({anchor_index, 1'b0});
      record.width_degrees = rss_pkg::ANGLE_W'({run_length, 1'b0});
      record.object_range  = matched_ping;
    end else begin
      record.start_angle   = rss_pkg::ANGLE_W'({anchor_index_next, 1'b0});
      record.width_degrees = rss_pkg::ANGLE_W'({run_length_next, 1'b0});
      record.object_range  = matched_ping_next;
    end

    summary              = '0;
    summary.is_summary   = 1'b1;
    summary.object_count = obj_total;
    summary.last_result  = 1'b1;

    push = '0;
    if (rec) begin
      push.item[0] = record;
      push.item[1] = summary;
      push.count   = last ? 2'd2 : 2'd1;
    end else begin
      push.item[0] = summary;
      push.item[1] = summary;
      push.count   = last ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    sample_index_next  = sample_index + 1'b1;
    objects_found_next = obj_total;
    if (last) begin
      sample_index_next  = '0;
      objects_found_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      anchor_valid  <= 1'b0;
      anchor_range  <= '0;
      anchor_index  <= '0;
      run_length    <= '0;
      object_open   <= 1'b0;
      matched_ping  <= '0;
      objects_found <= '0;
    end else if (step) begin
      sample_index  <= sample_index_next;
      objects_found <= objects_found_next;
      if (last) begin
        anchor_valid <= 1'b0;
        anchor_range <= '0;
        anchor_index <= '0;
        run_length   <= '0;
        object_open  <= 1'b0;
        matched_ping <= '0;
      end else begin
        anchor_valid <= anchor_valid_next;
        anchor_range <= anchor_range_next;
        anchor_index <= anchor_index_next;
        run_length   <= run_length_next;
        object_open  <= object_open_next;
        matched_ping <= matched_ping_next;
      end
    end
  end

endmodule

// ===== sv/rss_fifo.sv =====
// rss_fifo: small result queue taking up to two results per cycle, one out
// depends on rss_pkg
module rss_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_en,
  input  rss_pkg::push_t   push,
  output logic             space,
  output logic             result_valid,
  input  logic             result_ready,
  output rss_pkg::result_t result
);

  rss_pkg::result_t mem [rss_pkg::FIFO_DEPTH];

  logic [rss_pkg::FIFO_AW-1:0] wr_ptr, wr_ptr_next, rd_ptr;
  logic [rss_pkg::FIFO_CW-1:0] count, count_next;
  logic [1:0]                  n_push;
  logic                        pop;

  assign n_push       = push_en ? push.count : 2'd0;
  assign pop          = result_valid && result_ready;
  assign result_valid = (count != '0);
  assign result       = mem[rd_ptr];
  // room for the worst case of two results per request
  assign space        = (count <= rss_pkg::FIFO_CW'(rss_pkg::FIFO_DEPTH - 2));

  assign wr_ptr_next = wr_ptr + rss_pkg::FIFO_AW'(n_push);
  assign count_next  = count + rss_pkg::FIFO_CW'(n_push) - rss_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push.item[0];
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.item[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== sv/range_scan_object_segmenter.sv =====
// range_scan_object_segmenter: splits a range sweep into objects
// depends on rss_pkg, rss_core, rss_fifo
//
// Channels: sample (valid/ready) carries one sweep sample per request, IR and
// sonar range plus a last-sample flag; sample i lies at 2*i degrees. result
// (valid/ready) carries object records and the end-of-sweep summary, the last
// result of each request flagged by last_result. cfg (valid/ready, always
// ready) writes the four band tolerances and max_objects; write only while idle.
// Throughput: one sample per cycle while the queue has room. Each sample yields
// zero to two results; they enter a four-entry result queue at the accepting
// edge and, with an empty queue, show on the result port the next cycle.
// The sample port is ready while the queue has room for two results, so a
// sustained rate above one result per cycle is limited by the single read
// port of that queue.
// Reset: sweep state clears to sample index 0, tolerances take their defaults
// and the queue empties. When the receiver stalls, results wait in the queue
// and sample_ready drops once fewer than two slots are free.
module range_scan_object_segmenter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  rss_pkg::sample_t               sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output rss_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);

  rss_pkg::push_t push;
  logic           step;

  assign cfg_ready = 1'b1;
  assign step      = sample_valid && sample_ready;

  rss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .sample    (sample),
    .push      (push)
  );

  rss_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_en      (step),
    .push         (push),
    .space        (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== sv/rss_checker.sv =====
// rss_checker: port-level checks on the segmenter result channel
// depends on rss_pkg; bound to range_scan_object_segmenter below
module rss_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input rss_pkg::result_t result
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a summary always closes the results of its request
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_summary |->
      result.last_result && result.object_number == '0 &&
      result.object_count <= rss_pkg::MAX_OBJ_CAP)
    else $error("malformed summary");

  a_rec_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_summary |->
      result.object_count == '0 && result.object_number != '0 &&
      result.object_number <= rss_pkg::MAX_OBJ_CAP && result.width_degrees != '0)
    else $error("malformed object record");

endmodule

bind range_scan_object_segmenter rss_checker u_rss_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== verif/tb_range_scan_object_segmenter.sv =====
// tb_range_scan_object_segmenter: self-checking bench for the range scan segmenter
// sweep samples in, object records and sweep summaries checked against a scoreboard
// depends on rss_pkg and range_scan_object_segmenter
module tb_range_scan_object_segmenter;

  localparam int HOLD_CYCLES      = 300;
  localparam int DIR_N            = 19;
  localparam int FIRST_UNUSED_REG = int'(rss_pkg::REG_MAX_OBJECTS) + 1;

  typedef enum {RX_FREE, RX_PATCHY, RX_SLOW} rx_mode_t;

  // directed sweep: lone last sample, one run per band, object closed by the last request
  int dir_ir [DIR_N] = '{4095, 0, 40, 60, 20, 61, 35, 49, 50, 10,
                         19, 0, 4, 9, 0, 29, 38, 4095, 41};
  int dir_ping [DIR_N] = '{1023, 0, 17, 1023, 5, 3, 100, 101, 0, 200,
                           201, 202, 300, 999, 0, 7, 682, 341, 0};
  bit dir_end [DIR_N] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                          0, 0, 0, 1, 0, 0, 1, 0, 1};

  // predicts object records and summaries, holds them until the result port shows them
  class sweep_scoreboard;
    logic [rss_pkg::TOL_W-1:0]  tol_far, tol_mid, tol_near, tol_close;
    logic [rss_pkg::NUM_W-1:0]  max_obj;
    logic [rss_pkg::IDX_W-1:0]  sweep_idx;
    logic                       anchor_ok;
    logic [rss_pkg::IR_W-1:0]   anchor_ir;
    logic [rss_pkg::IDX_W-1:0]  anchor_at;
    logic [rss_pkg::RUN_W-1:0]  run_len;
    logic                       open_obj;
    logic [rss_pkg::PING_W-1:0] last_ping;
    logic [rss_pkg::NUM_W-1:0]  found;
    rss_pkg::result_t           awaited_records[$];
    int failures, n_samples, n_results, n_objects, n_sweeps;

    function new();
      tol_far   = rss_pkg::TOL_FAR_RST;
      tol_mid   = rss_pkg::TOL_MID_RST;
      tol_near  = rss_pkg::TOL_NEAR_RST;
      tol_close = rss_pkg::TOL_CLOSE_RST;
      max_obj   = rss_pkg::MAX_OBJ_RST;
      clear_sweep();
      failures  = 0;
      n_samples = 0;
      n_results = 0;
      n_objects = 0;
      n_sweeps  = 0;
    endfunction

    function void clear_sweep();
      sweep_idx = '0;
      anchor_ok = 1'b0;
      anchor_ir = '0;
      anchor_at = '0;
      run_len   = '0;
      open_obj  = 1'b0;
      last_ping = '0;
      found     = '0;
    endfunction

    function void write_register(logic [rss_pkg::CFG_IDX_W-1:0] idx,
                                 logic [rss_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rss_pkg::REG_TOL_FAR:     tol_far   = data;
        rss_pkg::REG_TOL_MID:     tol_mid   = data;
        rss_pkg::REG_TOL_NEAR:    tol_near  = data;
        rss_pkg::REG_TOL_CLOSE:   tol_close = data;
        rss_pkg::REG_MAX_OBJECTS: max_obj   = data[rss_pkg::NUM_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_run(ref rss_pkg::result_t recs[$]);
      rss_pkg::result_t r;
      if (anchor_ok && open_obj) begin
        found = found + 1'b1;
        r = '0;
        r.object_number = found;
        r.start_angle   = rss_pkg::ANGLE_W'(2 * int'(anchor_at));
        r.width_degrees = rss_pkg::ANGLE_W'(2 * int'(run_len));
        r.object_range  = last_ping;
        recs.push_back(r);
        n_objects++;
      end
      anchor_ok = 1'b0;
      run_len   = '0;
      open_obj  = 1'b0;
    endfunction

    function void note_sample(rss_pkg::sample_t s);
      rss_pkg::result_t recs[$];
      rss_pkg::result_t r;
      logic ends_sweep, try_anchor;
      logic [rss_pkg::TOL_W-1:0] tol;
      int lim, diff;
      n_samples++;
      ends_sweep = s.last_sample ||
                   (sweep_idx == rss_pkg::IDX_W'(rss_pkg::MAX_SAMPLES - 1));
      lim = (max_obj > rss_pkg::MAX_OBJ_CAP) ? int'(rss_pkg::MAX_OBJ_CAP) : int'(max_obj);
      if (sweep_idx != '0) begin
        try_anchor = 1'b1;
        if (anchor_ok) begin
          // tolerance band follows the anchor's own range
          if (anchor_ir > rss_pkg::BAND_FAR) tol = tol_far;
          else if (anchor_ir >= rss_pkg::BAND_MID) tol = tol_mid;
          else if (anchor_ir >= rss_pkg::BAND_NEAR) tol = tol_near;
          else tol = tol_close;
          diff = int'(s.ir_distance) - int'(anchor_ir);
          if (diff < 0) diff = -diff;
          if (diff <= int'(tol)) begin
            run_len   = run_len + 1'b1;
            last_ping = s.ping_distance;
            if (run_len == 1 && int'(found) < lim) open_obj = 1'b1;
            try_anchor = 1'b0;
          end else begin
            close_run(recs);
          end
        end
        // the sample that broke the run is itself tried as the next anchor
        if (try_anchor && s.ir_distance <= rss_pkg::ANCHOR_LIMIT) begin
          anchor_ok = 1'b1;
          anchor_ir = s.ir_distance;
          anchor_at = sweep_idx;
          run_len   = '0;
          open_obj  = 1'b0;
        end
      end
      if (ends_sweep) begin
        close_run(recs);
        r = '0;
        r.is_summary   = 1'b1;
        r.object_count = found;
        recs.push_back(r);
        n_sweeps++;
        clear_sweep();
      end else begin
        sweep_idx = sweep_idx + 1'b1;
      end
      foreach (recs[i]) begin
        recs[i].last_result = (i == recs.size() - 1);
        awaited_records.push_back(recs[i]);
      end
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(rss_pkg::result_t got);
      rss_pkg::result_t want;
      n_results++;
      if (awaited_records.size() == 0) begin
        $error("result with nothing awaited: summary %0d number %0d count %0d",
               got.is_summary, got.object_number, got.object_count);
        failures++;
        return;
      end
      want = awaited_records.pop_front();
      check_field("is_summary", want.is_summary, got.is_summary);
      check_field("object_number", want.object_number, got.object_number);
      check_field("start_angle", want.start_angle, got.start_angle);
      check_field("width_degrees", want.width_degrees, got.width_degrees);
      check_field("object_range", want.object_range, got.object_range);
      check_field("object_count", want.object_count, got.object_count);
      check_field("last_result", want.last_result, got.last_result);
    endfunction

    function int outstanding();
      return awaited_records.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           sample_valid;
  logic                           sample_ready;
  rss_pkg::sample_t               sample;
  logic                           result_valid;
  logic                           result_ready;
  rss_pkg::result_t               result;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data;

  bit              hold_off_req;
  sweep_scoreboard sb;

  range_scan_object_segmenter u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // receiver: random stall pattern, plus one long hold-off on demand
  initial begin : receiver
    rx_mode_t mode;
    int seg_left;
    result_ready = 1'b0;
    mode = RX_FREE;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        result_ready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 60);
          mode = rx_mode_t'($urandom_range(0, 2));
        end
        seg_left--;
        case (mode)
          RX_FREE:   result_ready <= 1'b1;
          RX_PATCHY: result_ready <= 1'($urandom_range(0, 1));
          default:   result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [rss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  task automatic configure(input logic [rss_pkg::CFG_DATA_W-1:0] tf, tm, tn, tc, mo,
                           input bit poke_unused);
    write_reg(rss_pkg::REG_TOL_FAR, tf);
    write_reg(rss_pkg::REG_TOL_MID, tm);
    write_reg(rss_pkg::REG_TOL_NEAR, tn);
    write_reg(rss_pkg::REG_TOL_CLOSE, tc);
    write_reg(rss_pkg::REG_MAX_OBJECTS, mo);
    if (poke_unused) begin
      for (int k = FIRST_UNUSED_REG; k < 2 ** rss_pkg::CFG_IDX_W; k++)
        write_reg(rss_pkg::CFG_IDX_W'(k), rss_pkg::CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input int ir, input int ping, input bit ends);
    rss_pkg::sample_t s;
    s.ir_distance   = rss_pkg::IR_W'(ir);
    s.ping_distance = rss_pkg::PING_W'(ping);
    s.last_sample   = ends;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(s);
  endtask

  task automatic pause_sender(input int cycles);
    sample_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // mostly a random walk over the anchor ranges so runs form, some wild ranges
  task automatic send_random(input int count, input int gap_pct, input int last_div);
    int walk, burst, pick, ir;
    bit ends;
    walk  = $urandom_range(0, 45);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 99) < gap_pct) pause_sender($urandom_range(1, 10));
      end
      burst--;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        walk = walk + int'($urandom_range(0, 24)) - 12;
        if (walk < 0) walk = 0;
        if (walk > 63) walk = 63;
        ir = walk;
      end else if (pick < 17) begin
        ir = $urandom_range(0, 40);
      end else begin
        ir = $urandom_range(0, 4095);
      end
      ends = (last_div > 0) && ($urandom_range(1, last_div) == 1);
      send_sample(ir, $urandom_range(0, 1023), ends);
    end
    sample_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    sb = new();
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default bands: lone last sample, one run per band, object closed by the last request
    configure(8'd20, 8'd14, 8'd9, 8'd4, 8'h04, 1'b1);
    for (int i = 0; i < DIR_N; i++) send_sample(dir_ir[i], dir_ping[i], dir_end[i]);
    sample_valid <= 1'b0;
    drain();

    // zero tolerances, no objects allowed
    configure(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0);
    send_random(100, 30, 10);
    drain();

    // widest tolerances, max_objects above the cap
    configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_random(100, 30, 12);
    drain();

    // one object per sweep, back-to-back requests
    configure(8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
              8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)), 8'hF1, 1'b0);
    send_random(120, 0, 8);
    drain();

    // receiver holds off while short sweeps keep arriving
    configure(8'd20, 8'd14, 8'd9, 8'd4, 8'h08, 1'b0);
    hold_off_req = 1'b1;
    send_random(60, 0, 3);
    drain();

    // sweep runs past the sample limit without a last flag
    configure(8'($urandom_range(5, 25)), 8'($urandom_range(5, 25)),
              8'($urandom_range(5, 25)), 8'($urandom_range(5, 25)), 8'h06, 1'b0);
    send_random(300, 20, 0);
    drain();

    repeat (4) begin
      configure(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                8'($urandom), 1'($urandom_range(0, 1)));
      send_random(120, $urandom_range(0, 60), $urandom_range(4, 30));
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d samples in %0d sweeps, five register settings and more",
             sb.n_samples, sb.n_sweeps);
    $display("%0d object records and %0d summaries predicted, %0d results checked",
             sb.n_objects, sb.n_sweeps, sb.n_results);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
